/* rtl/fdl_pkg.sv */
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared constants and register codes of the fractional delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

  localparam int DEPTH_DEF       = 65536;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;

  // delay field: unsigned 17.8 fixed point
  localparam int DELAY_BITS = 25;

  // configuration port
  localparam int SIZE_BITS  = 17;
  localparam int SIZE_RESET = 65536;
  localparam int ADDR_BITS  = 3;
  localparam int DATA_BITS  = 32;

  typedef enum logic [0:0] {
    REG_BUFFER_SIZE = 1'b0,
    REG_INTERPOLATE = 1'b1
  } reg_idx_t;

endpackage

/* rtl/fdl_if.sv */
// ----------------------------------------------------------------------------
// fdl_feed_if / fdl_tap_if
// Valid/ready channels carrying samples into and out of the delay line.
// ----------------------------------------------------------------------------
interface fdl_feed_if #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
);
  import fdl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [DELAY_BITS-1:0]         delay;

  modport source (output valid, output sample_in, output delay, input ready);
  modport sink   (input valid, input sample_in, input delay, output ready);
endinterface

interface fdl_tap_if #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF
);
  import fdl_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

/* rtl/fractional_delay_line.sv */
// ----------------------------------------------------------------------------
// fractional_delay_line
// Circular sample store with a fractional read tap and linear interpolation.
// ----------------------------------------------------------------------------
//  channel | role  | handshake           | payload
//  feed    | sink  | valid/ready         | sample_in (signed), delay (17.8)
//  tap     | src   | valid/ready         | sample_out (signed)
//  apb     | slave | psel/penable/pready | buffer_size @0x0, interpolate @0x4
//
//  One transaction per cycle while the tap is drained. Each item's store
//  write and both neighbor reads happen at one edge in stage D, in item
//  order, on a store with one write and two read ports. Reset is
//  synchronous; unwritten slots read as zero through a fill count, so no
//  clearing pass is needed. A stalled tap backs up stage by stage;
//  feed.ready drops only when all stages hold an item.
// ----------------------------------------------------------------------------
module fractional_delay_line #(
  parameter int DEPTH       = fdl_pkg::DEPTH_DEF,
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  fdl_feed_if.sink                      feed,
  fdl_tap_if.source                     tap,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdl_pkg::ADDR_BITS-1:0] paddr,
  input  logic [fdl_pkg::DATA_BITS-1:0] pwdata,
  output logic [fdl_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);
  import fdl_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 1;
  localparam int FW = (FRAC_BITS > 0) ? FRAC_BITS : 1;
  localparam int XW = ((SW + FRAC_BITS > DELAY_BITS) ? SW + FRAC_BITS : DELAY_BITS) + 2;
  localparam int SIZE_INIT = (SIZE_RESET > DEPTH) ? DEPTH : SIZE_RESET;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_OWN
  } src_t;

  // configuration and item state
  logic [SW-1:0] size;
  logic          interp;
  logic [AW-1:0] wp;
  logic [SW-1:0] rl;
  logic [SW-1:0] hw;
  logic          started;

  // register port
  reg_idx_t              reg_idx;
  logic                  wr;
  logic [SIZE_BITS-1:0]  wval;
  logic [31:0]           wval32;
  logic [SW-1:0]         size_wr;

  // accept stage
  logic          acc;
  logic [XW-1:0] size_fx;
  logic [XW-1:0] wp_fx;
  logic [XW-1:0] d_in;
  logic [XW-1:0] d_cl;
  logic          go;
  logic [SW-1:0] wp_inc;
  logic [SW-1:0] wp_next;
  logic [SW-1:0] rl_next;
  logic [SW-1:0] hw_next;

  // stage B
  logic                   b_v;
  logic [SAMPLE_BITS-1:0] b_sample;
  logic [AW-1:0]          b_wp;
  logic [SW-1:0]          b_rl;
  logic [SW-1:0]          b_hw;
  logic [XW-1:0]          b_d;
  logic                   b_go;
  logic [XW-1:0]          bwp_fx;
  logic [XW-1:0]          brl_fx;

  // stage C
  logic                   c_v;
  logic [XW-1:0]          c_pos;
  logic [SAMPLE_BITS-1:0] c_sample;
  logic [AW-1:0]          c_wp;
  logic [SW-1:0]          c_rl;
  logic [SW-1:0]          c_hw;
  logic                   c_go;
  logic [XW-1:0]          pos2;

  // stage D
  logic                   d_v;
  logic [AW-1:0]          d_idx;
  logic [FW-1:0]          d_frac;
  logic [SAMPLE_BITS-1:0] d_sample;
  logic [AW-1:0]          d_wp;
  logic [SW-1:0]          d_rl;
  logic [SW-1:0]          d_hw;
  logic                   d_go;
  logic [SW-1:0]          hi_inc;
  logic [SW-1:0]          hi_wrap;
  logic [AW-1:0]          hi_addr;
  src_t                   lo_src;
  src_t                   hi_src;

  // stage E
  logic                          e_v;
  src_t                          e_lo_src;
  src_t                          e_hi_src;
  logic [FW-1:0]                 e_frac;
  logic [SAMPLE_BITS-1:0]        e_sample;
  logic [SAMPLE_BITS-1:0]        rd_lo;
  logic [SAMPLE_BITS-1:0]        rd_hi;
  logic signed [SAMPLE_BITS-1:0] lo_val;
  logic signed [SAMPLE_BITS-1:0] hi_val;

  logic en_b, en_c, en_d, en_e, blend_ready;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign wr      = psel && penable && pwrite;
  assign wval    = pwdata[SIZE_BITS-1:0];
  assign wval32  = 32'(wval);

  always_comb begin
    priority if (wval32 == 32'd0) begin
      size_wr = SW'(1);
    end else if (wval32 > 32'(DEPTH)) begin
      size_wr = SW'(DEPTH);
    end else begin
      size_wr = SW'(wval32);
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BUFFER_SIZE: prdata = DATA_BITS'(size);
      REG_INTERPOLATE: prdata = DATA_BITS'(interp);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- handshake
  assign en_e      = !e_v || blend_ready;
  assign en_d      = !d_v || en_e;
  assign en_c      = !c_v || en_d;
  assign en_b      = !b_v || en_c;
  assign feed.ready = en_b;
  assign acc       = feed.valid && en_b;

  // ---------------------------------------------------------------- accept
  assign size_fx = XW'(size) << FRAC_BITS;
  assign wp_fx   = XW'(wp) << FRAC_BITS;
  assign d_in    = XW'(feed.delay);
  assign d_cl    = (d_in > size_fx) ? size_fx : d_in;
  assign go      = started || (wp_fx > d_cl);

  assign wp_inc  = SW'(wp) + SW'(1);
  assign wp_next = (wp_inc >= size) ? '0 : wp_inc;
  assign rl_next = (wp_next > rl) ? size : rl;
  // written slots always form a prefix of the store
  assign hw_next = (SW'(wp) == hw) ? hw + SW'(1) : hw;

  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= SW'(SIZE_INIT);
      interp  <= 1'b1;
      wp      <= '0;
      rl      <= SW'(SIZE_INIT);
      hw      <= '0;
      started <= 1'b0;
    end else begin
      if (wr && reg_idx == REG_BUFFER_SIZE) begin
        size <= size_wr;
        if (rl > size_wr) begin
          rl <= size_wr;
        end
        if (SW'(wp) >= size_wr) begin
          wp <= '0;
        end
      end else if (acc) begin
        wp      <= wp_next[AW-1:0];
        rl      <= rl_next;
        hw      <= hw_next;
        started <= go;
      end
      if (wr && reg_idx == REG_INTERPOLATE) begin
        interp <= pwdata[0];
      end
    end
  end

  // ---------------------------------------------------------------- pipeline
  assign bwp_fx = XW'(b_wp) << FRAC_BITS;
  assign brl_fx = XW'(b_rl) << FRAC_BITS;
  // negative wrapped position only after the size grew; one add fixes it
  assign pos2   = c_pos[XW-1] ? c_pos + size_fx : c_pos;

  assign hi_inc  = SW'(d_idx) + SW'(1);
  assign hi_wrap = (hi_inc >= d_rl) ? hi_inc - d_rl : hi_inc;
  assign hi_addr = hi_wrap[AW-1:0];

  // own slot is written at the same edge, so it is forwarded
  always_comb begin
    priority if (!d_go) begin
      lo_src = SRC_ZERO;
    end else if (d_idx == d_wp) begin
      lo_src = SRC_OWN;
    end else if (SW'(d_idx) < d_hw) begin
      lo_src = SRC_MEM;
    end else begin
      lo_src = SRC_ZERO;
    end
    priority if (!d_go || !interp) begin
      hi_src = SRC_ZERO;
    end else if (hi_addr == d_wp) begin
      hi_src = SRC_OWN;
    end else if (hi_wrap < d_hw) begin
      hi_src = SRC_MEM;
    end else begin
      hi_src = SRC_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
    end else begin
      if (en_b) b_v <= acc;
      if (en_c) c_v <= b_v;
      if (en_d) d_v <= c_v;
      if (en_e) e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_sample <= feed.sample_in;
      b_wp     <= wp;
      b_rl     <= rl;
      b_hw     <= hw_next;
      b_d      <= d_cl;
      b_go     <= go;
    end
    if (en_c && b_v) begin
      c_pos    <= (b_d > bwp_fx) ? brl_fx + bwp_fx - b_d : bwp_fx - b_d;
      c_sample <= b_sample;
      c_wp     <= b_wp;
      c_rl     <= b_rl;
      c_hw     <= b_hw;
      c_go     <= b_go;
    end
    if (en_d && c_v) begin
      d_idx    <= pos2[FRAC_BITS +: AW];
      d_frac   <= (c_go && interp && FRAC_BITS > 0) ? pos2[FW-1:0] : '0;
      d_sample <= c_sample;
      d_wp     <= c_wp;
      d_rl     <= c_rl;
      d_hw     <= c_hw;
      d_go     <= c_go;
    end
    if (en_e && d_v) begin
      e_lo_src <= lo_src;
      e_hi_src <= hi_src;
      e_frac   <= d_frac;
      e_sample <= d_sample;
    end
  end

  // store: write and both reads at one edge, reads see the old contents
  always_ff @(posedge clk) begin
    if (en_e && d_v) begin
      mem[d_wp] <= d_sample;
      rd_lo     <= mem[d_idx];
      rd_hi     <= mem[hi_addr];
    end
  end

  always_comb begin
    unique case (e_lo_src)
      SRC_MEM: lo_val = rd_lo;
      SRC_OWN: lo_val = e_sample;
      default: lo_val = '0;
    endcase
    unique case (e_hi_src)
      SRC_MEM: hi_val = rd_hi;
      SRC_OWN: hi_val = e_sample;
      default: hi_val = '0;
    endcase
  end

  fdl_blend #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .FW          (FW)
  ) u_blend (
    .clk      (clk),
    .rst      (rst),
    .in_valid (e_v),
    .in_ready (blend_ready),
    .lo       (lo_val),
    .hi       (hi_val),
    .frac     (e_frac),
    .tap      (tap)
  );

`ifndef ASSERT_OFF
  a_wp_in_size: assert property (@(posedge clk) disable iff (rst)
    SW'(wp) < size)
    else $error("write position not below buffer size");

  a_rl_le_size: assert property (@(posedge clk) disable iff (rst)
    rl <= size)
    else $error("read limit above buffer size");

  a_fill_prefix: assert property (@(posedge clk) disable iff (rst)
    SW'(wp) <= hw && hw <= SW'(DEPTH))
    else $error("fill count lost track of write position");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !feed.ready |-> (tap.valid && !tap.ready))
    else $error("feed stalled while tap is free");
`endif

endmodule

/* rtl/fdl_blend.sv */
// ----------------------------------------------------------------------------
// fdl_blend
// Linear blend low + trunc(frac * (high - low) / 2^FRAC_BITS), two stages:
// product register, then output register driving the tap channel.
// ----------------------------------------------------------------------------
module fdl_blend #(
  parameter int SAMPLE_BITS = fdl_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fdl_pkg::FRAC_BITS_DEF,
  parameter int FW          = (FRAC_BITS > 0) ? FRAC_BITS : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] lo,
  input  logic signed [SAMPLE_BITS-1:0] hi,
  input  logic [FW-1:0]                 frac,
  fdl_tap_if.source                     tap
);
  import fdl_pkg::*;

  localparam int PW = SAMPLE_BITS + FW + 2;

  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PW-1:0]          prod_c;
  logic                          f_v;
  logic signed [PW-1:0]          f_prod;
  logic signed [SAMPLE_BITS-1:0] f_lo;
  logic signed [PW-1:0]          bias;
  logic signed [PW-1:0]          step;
  logic signed [PW-1:0]          res;
  logic                          en_o;

  assign diff   = (SAMPLE_BITS+1)'(hi) - (SAMPLE_BITS+1)'(lo);
  assign prod_c = PW'($signed({1'b0, frac})) * PW'(diff);

  // truncate toward zero: bias negative products before the shift
  assign bias = f_prod[PW-1] ? PW'((1 << FRAC_BITS) - 1) : '0;
  assign step = (f_prod + bias) >>> FRAC_BITS;
  assign res  = PW'(f_lo) + step;

  assign en_o     = !tap.valid || tap.ready;
  assign in_ready = !f_v || en_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v       <= 1'b0;
      tap.valid <= 1'b0;
    end else begin
      if (in_ready) begin
        f_v <= in_valid;
      end
      if (en_o) begin
        tap.valid <= f_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      f_prod <= prod_c;
      f_lo   <= lo;
    end
    if (en_o && f_v) begin
      tap.sample_out <= res[SAMPLE_BITS-1:0];
    end
  end

endmodule
